// ----- sv/ctiu_pkg.sv -----
// ----------------------------------------------------------------------------
// ctiu_pkg
// Shared types and constants of the cubic table interpolator unit.
// ----------------------------------------------------------------------------
package ctiu_pkg;

	localparam int DEFAULT_TABLE_DEPTH  = 4096;
	localparam int DEFAULT_SAMPLE_WIDTH = 24;

	localparam int MESH_W    = 13;  // mesh_count register
	localparam int STEP_W    = 32;  // inv_step register, Q16.16
	localparam int CFG_W     = 32;  // widest register
	localparam int CFG_IDX_W = 1;
	localparam int IDX_W     = 12;  // entry_index field
	localparam int VAL_W     = 24;  // entry_value field, Q4.20
	localparam int RAD_W     = 24;  // query_radius field, Q8.16
	localparam int OUT_W     = 32;  // interp_value field, Q12.20
	localparam int PROD_W    = RAD_W + STEP_W;
	localparam int IQ_W      = PROD_W - 32;
	localparam int FRAC_W    = 16;
	localparam int WEIGHT_W  = 33;  // signed Q.30 weight
	localparam int NTAP      = 4;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 32;

	// floor(m / 3) == (m * INV3) >> 33 for any 32-bit m
	localparam logic [31:0] INV3 = 32'hAAAA_AAAB;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MESH_COUNT = 1'b0,
		REG_INV_STEP   = 1'b1
	} reg_idx_t;

	typedef logic signed [WEIGHT_W-1:0] weight_t;

	// stage-2 request into the table banks
	typedef struct packed {
		logic             adv;
		logic             load;
		logic [IDX_W-1:0] index;
		logic [IQ_W-1:0]  iq;
	} tbl_req_t;

endpackage

// ----- sv/ctiu_ram.sv -----
// ----------------------------------------------------------------------------
// ctiu_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ctiu_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/ctiu_table.sv -----
// ----------------------------------------------------------------------------
// ctiu_table
// Sample table in four interleaved banks. Entry i lives in bank i mod 4, so
// the four neighbours of one query come from four different banks at once.
// ----------------------------------------------------------------------------
module ctiu_table
	import ctiu_pkg::*;
#(
	parameter int TABLE_DEPTH  = DEFAULT_TABLE_DEPTH,
	parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
) (
	input  logic                           clk,
	input  tbl_req_t                       req,
	input  logic [SAMPLE_WIDTH-1:0]        wr_value,
	input  logic [MESH_W-1:0]              mesh_count,
	output logic signed [SAMPLE_WIDTH-1:0] smp_s4 [NTAP]
);

	localparam int BANK_DEPTH = (TABLE_DEPTH + 3) / 4;
	localparam int ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int NIDX_W     = IQ_W + 1;

	logic                    wr_ok;
	logic [ROW_W-1:0]        wr_row;
	logic [ROW_W-1:0]        rd_row [NTAP];
	logic [SAMPLE_WIDTH-1:0] rd_data [NTAP];
	logic [NTAP-1:0]         nb_ok;
	logic [NTAP-1:0]         nb_ok_s3;
	logic [1:0]              lo_s3;

	assign wr_ok  = req.load && (32'(req.index) < 32'(TABLE_DEPTH));
	assign wr_row = ROW_W'(req.index >> 2);

	always_comb begin
		logic [NIDX_W-1:0] nidx;
		for (int k = 0; k < NTAP; k++) begin
			// bank k holds the neighbour whose low index bits equal k
			rd_row[k] = ROW_W'((req.iq >> 2) + ((2'(k) < req.iq[1:0]) ? 1 : 0));
			nidx      = NIDX_W'(req.iq) + NIDX_W'(k);
			nb_ok[k]  = (nidx < NIDX_W'(mesh_count)) && (nidx < NIDX_W'(TABLE_DEPTH));
		end
	end

	for (genvar b = 0; b < NTAP; b++) begin : g_bank
		ctiu_ram #(
			.WIDTH (SAMPLE_WIDTH),
			.DEPTH (BANK_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (req.adv && wr_ok && (req.index[1:0] == 2'(b))),
			.waddr (wr_row),
			.wdata (wr_value),
			.re    (req.adv),
			.raddr (rd_row[b]),
			.rdata (rd_data[b])
		);
	end

	always_ff @(posedge clk) begin
		if (req.adv) begin
			nb_ok_s3 <= nb_ok;
			lo_s3    <= req.iq[1:0];
		end
	end

	// rotate bank outputs into neighbour order, zero what lies past the end
	always_ff @(posedge clk) begin
		logic [1:0] sel;
		if (req.adv) begin
			for (int k = 0; k < NTAP; k++) begin
				sel       = lo_s3 + 2'(k);
				smp_s4[k] <= nb_ok_s3[k] ? $signed(rd_data[sel]) : '0;
			end
		end
	end

endmodule

// ----- sv/ctiu_weights.sv -----
// ----------------------------------------------------------------------------
// ctiu_weights
// Four-point Lagrange weights from the Q.16 fraction, Q.30 result, four
// registered stages: pair products, triple products, divide, sign.
// ----------------------------------------------------------------------------
module ctiu_weights
	import ctiu_pkg::*;
(
	input  logic              clk,
	input  logic              adv,
	input  logic [FRAC_W-1:0] frac,
	output weight_t           w_s6 [NTAP]
);

	logic [16:0] x1;
	logic [17:0] x2;
	logic [17:0] x3;

	logic [15:0] x0_s3;
	logic [16:0] x1_s3;
	logic [17:0] x2_s3;
	logic [17:0] x3_s3;
	logic [34:0] p12_s3;
	logic [33:0] p03_s3;

	logic [52:0] t0_s4;
	logic [51:0] t1_s4;
	logic [50:0] t2_s4;
	logic [50:0] t3_s4;

	logic [63:0] q0_s5;
	logic [63:0] q3_s5;
	logic [31:0] h1_s5;
	logic [31:0] h2_s5;

	assign x1 = 17'd65536  - 17'(frac);
	assign x2 = 18'd131072 - 18'(frac);
	assign x3 = 18'd196608 - 18'(frac);

	always_ff @(posedge clk) begin
		if (adv) begin
			x0_s3  <= frac;
			x1_s3  <= x1;
			x2_s3  <= x2;
			x3_s3  <= x3;
			p12_s3 <= 35'(x1) * 35'(x2);
			p03_s3 <= 34'(frac) * 34'(x3);

			t0_s4 <= 53'(p12_s3) * 53'(x3_s3);
			t1_s4 <= 52'(p03_s3) * 52'(x2_s3);
			t2_s4 <= 51'(p03_s3) * 51'(x1_s3);
			t3_s4 <= 51'(p12_s3) * 51'(x0_s3);

			// >>18 then /6 equals >>19 then /3
			q0_s5 <= 64'(32'(t0_s4 >> 19)) * 64'(INV3);
			q3_s5 <= 64'(32'(t3_s4 >> 19)) * 64'(INV3);
			h1_s5 <= 32'(t1_s4 >> 19);
			h2_s5 <= 32'(t2_s4 >> 19);

			w_s6[0] <= weight_t'({2'b00, q0_s5[63:33]});
			w_s6[1] <= weight_t'({1'b0, h1_s5});
			w_s6[2] <= -weight_t'({1'b0, h2_s5});
			w_s6[3] <= weight_t'({2'b00, q3_s5[63:33]});
		end
	end

endmodule

// ----- sv/ctiu_mac.sv -----
// ----------------------------------------------------------------------------
// ctiu_mac
// Weighted sum of the four neighbours, rounding to Q12.20 and saturation.
// ----------------------------------------------------------------------------
module ctiu_mac
	import ctiu_pkg::*;
#(
	parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
) (
	input  logic                           clk,
	input  logic                           adv,
	input  logic signed [SAMPLE_WIDTH-1:0] smp_s4 [NTAP],
	input  weight_t                        w_s6 [NTAP],
	output logic [OUT_W-1:0]               value
);

	localparam int PW = SAMPLE_WIDTH + WEIGHT_W;
	localparam int TW = PW + 2;
	localparam logic signed [TW-1:0] RND    = {{(TW-30){1'b0}}, 1'b1, 29'b0};
	localparam logic signed [TW-1:0] SAT_HI = {{(TW-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [TW-1:0] SAT_LO = {{(TW-31){1'b1}}, {31{1'b0}}};

	logic signed [SAMPLE_WIDTH-1:0] smp_s5 [NTAP];
	logic signed [SAMPLE_WIDTH-1:0] smp_s6 [NTAP];
	logic signed [PW-1:0]           prod_s7 [NTAP];
	logic signed [TW-1:0]           sa_s8;
	logic signed [TW-1:0]           sb_s8;
	logic signed [TW-1:0]           total_s9;
	logic signed [TW-1:0]           y;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NTAP; k++) begin
				smp_s5[k]  <= smp_s4[k];
				smp_s6[k]  <= smp_s5[k];
				prod_s7[k] <= smp_s6[k] * w_s6[k];
			end
			// rounding offset rides along in the first pair
			sa_s8    <= TW'(prod_s7[0]) + TW'(prod_s7[1]) + RND;
			sb_s8    <= TW'(prod_s7[2]) + TW'(prod_s7[3]);
			total_s9 <= sa_s8 + sb_s8;
		end
	end

	always_comb begin
		y = total_s9 >>> 30;
		if (y > SAT_HI) begin
			value = OUT_W'(SAT_HI);
		end else if (y < SAT_LO) begin
			value = OUT_W'(SAT_LO);
		end else begin
			value = OUT_W'(y);
		end
	end

endmodule

// ----- sv/cubic_table_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// cubic_table_interpolator_unit
// Uniform-grid sample table with four-point cubic Lagrange interpolation.
// ----------------------------------------------------------------------------
// The unit takes one item per clock, load or query, with no bubbles between
// them except while it holds for a stalled output. A query result leaves the
// output register after the radius multiply, the banked table read, the four
// weight stages and the three multiply-accumulate stages. The table sits in
// four banks of registered-read RAM, entry i in bank i mod 4, so the four
// neighbours of a query come out in a single read. Loads and queries pass
// the table at the same stage, so a query always sees every earlier load.
// Loads give no result. The table is not cleared at reset: read only
// entries that were written. When the output is stalled, the pipeline keeps
// accepting items until a query reaches its last stage, then holds as one.
// ----------------------------------------------------------------------------
module cubic_table_interpolator_unit
	import ctiu_pkg::*;
#(
	parameter int TABLE_DEPTH  = DEFAULT_TABLE_DEPTH,
	parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// entry_index [11:0], entry_value [35:12], query_radius [59:36], zero fill
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// operation [0]
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// interp_value [31:0]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// beyond_table [0]
	output logic                  m_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	logic [MESH_W-1:0] mesh_count_q;
	logic [STEP_W-1:0] inv_step_q;

	logic adv;
	logic in_acc;

	logic             v_s1;
	op_t              op_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [VAL_W-1:0] val_s1;
	logic [RAD_W-1:0] rad_s1;

	logic              v_s2;
	op_t               op_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic [VAL_W-1:0]  val_s2;
	logic [PROD_W-1:0] p_s2;
	logic [IQ_W-1:0]   iq_s2;
	logic              qv_s2;
	logic              beyond_s2;

	logic qv_s3, qv_s4, qv_s5, qv_s6, qv_s7, qv_s8, qv_s9;
	logic by_s3, by_s4, by_s5, by_s6, by_s7, by_s8, by_s9;

	tbl_req_t                       tbl_req;
	logic signed [SAMPLE_WIDTH-1:0] smp_s4 [NTAP];
	weight_t                        w_s6 [NTAP];
	logic [OUT_W-1:0]               mac_value;

	logic             out_valid_q;
	logic [OUT_W-1:0] out_value_q;
	logic             out_beyond_q;

	// stall only when a finished query meets a full, untaken output register
	assign adv      = !(qv_s9 && out_valid_q && !m_tready);
	assign s_tready = adv;
	assign in_acc   = s_tvalid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mesh_count_q <= '0;
			inv_step_q   <= STEP_W'(65536);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MESH_COUNT: mesh_count_q <= cfg_data[MESH_W-1:0];
				REG_INV_STEP:   inv_step_q   <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			qv_s3 <= 1'b0;
			qv_s4 <= 1'b0;
			qv_s5 <= 1'b0;
			qv_s6 <= 1'b0;
			qv_s7 <= 1'b0;
			qv_s8 <= 1'b0;
			qv_s9 <= 1'b0;
		end else if (adv) begin
			v_s1  <= in_acc;
			v_s2  <= v_s1;
			qv_s3 <= qv_s2;
			qv_s4 <= qv_s3;
			qv_s5 <= qv_s4;
			qv_s6 <= qv_s5;
			qv_s7 <= qv_s6;
			qv_s8 <= qv_s7;
			qv_s9 <= qv_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1  <= op_t'(s_tuser);
			idx_s1 <= s_tdata[IDX_W-1:0];
			val_s1 <= s_tdata[IDX_W +: VAL_W];
			rad_s1 <= s_tdata[IDX_W+VAL_W +: RAD_W];

			op_s2  <= op_s1;
			idx_s2 <= idx_s1;
			val_s2 <= val_s1;
			p_s2   <= PROD_W'(rad_s1) * PROD_W'(inv_step_q);

			by_s3 <= beyond_s2;
			by_s4 <= by_s3;
			by_s5 <= by_s4;
			by_s6 <= by_s5;
			by_s7 <= by_s6;
			by_s8 <= by_s7;
			by_s9 <= by_s8;
		end
	end

	assign iq_s2     = p_s2[PROD_W-1:32];
	assign qv_s2     = v_s2 && (op_s2 == OP_QUERY);
	assign beyond_s2 = iq_s2 >= IQ_W'(mesh_count_q);

	assign tbl_req = '{
		adv:   adv,
		load:  v_s2 && (op_s2 == OP_LOAD),
		index: idx_s2,
		iq:    iq_s2
	};

	ctiu_table #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_table (
		.clk        (clk),
		.req        (tbl_req),
		.wr_value   (SAMPLE_WIDTH'($signed(val_s2))),
		.mesh_count (mesh_count_q),
		.smp_s4     (smp_s4)
	);

	ctiu_weights u_weights (
		.clk  (clk),
		.adv  (adv),
		.frac (p_s2[31:16]),
		.w_s6 (w_s6)
	);

	ctiu_mac #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_mac (
		.clk    (clk),
		.adv    (adv),
		.smp_s4 (smp_s4),
		.w_s6   (w_s6),
		.value  (mac_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && qv_s9) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && qv_s9) begin
			out_value_q  <= by_s9 ? '0 : mac_value;
			out_beyond_q <= by_s9;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = out_beyond_q;

endmodule

// ----- sv/ctiu_checker.sv -----
// ----------------------------------------------------------------------------
// ctiu_checker
// Port-level checks of the cubic table interpolator unit, bound to the top.
// ----------------------------------------------------------------------------
module ctiu_checker
	import ctiu_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_DATA_W-1:0]  s_tdata,
	input logic                  s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tuser,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_W-1:0]      cfg_data
);

	// hold a stalled result item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result item changed");

	// a query past the mesh end reports zero
	a_beyond_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("beyond_table result with nonzero value");

	// input backpressure comes only from a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output stall");

	// a new result is loaded only while the pipe advances
	a_load_adv: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tready))
		else $error("result loaded while pipeline held");

	// no result is valid out of reset; input and config ports go unchecked
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result valid out of reset");

endmodule

bind cubic_table_interpolator_unit ctiu_checker u_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cubic table interpolator unit.
// ----------------------------------------------------------------------------
// A short directed table covers reset values, sample extremes, exact grid
// points, neighbours past the mesh and past the table, and the zero grid
// step. Random loads and queries follow over several register settings,
// with random idling on both stream sides and one long output hold per
// setting. Every query result is checked against its directed value or
// the bench's fixed-point Lagrange predictor. Before any query, the bench
// loads each entry the query would read, so no unwritten entry is used.
// ----------------------------------------------------------------------------
module tb;
	import ctiu_pkg::*;

	localparam int TB_DEPTH      = DEFAULT_TABLE_DEPTH;
	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 7;
	localparam int DRAIN_CYCLES  = 24;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASES        = 7;
	localparam int PHASE_ITEMS   = 150;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic [OUT_W-1:0] value;
		logic             beyond;
	} interp_result_t;

	typedef enum logic {
		ROW_SETTING,
		ROW_ITEM
	} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [MESH_W-1:0] mesh;
		logic [STEP_W-1:0] step;
		op_t               op;
		logic [IDX_W-1:0]  idx;
		logic [VAL_W-1:0]  val;
		logic [RAD_W-1:0]  rad;
		bit                typed;
		interp_result_t    want;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  cfg_we;
	reg_idx_t              cfg_index;
	logic [CFG_W-1:0]      cfg_data;

	// bench copy of the block state
	logic signed [VAL_W-1:0] sample_mem [TB_DEPTH];
	bit                      written_mem [TB_DEPTH];
	logic [MESH_W-1:0]       mesh_reg = '0;
	logic [STEP_W-1:0]       step_reg = 32'h0001_0000;

	interp_result_t pending_results [$];
	stim_row_t      dir_rows [$];

	logic [MESH_W-1:0] phase_mesh [PHASES] = '{13'd64, 13'd4096, 13'd0, 13'd4096,
		13'd1, 13'd4096, 13'd300};
	logic [STEP_W-1:0] phase_step [PHASES] = '{32'h0001_0000, 32'hFFFF_FFFF,
		32'h0001_2345, 32'h0000_0000, 32'h0010_0000, 32'h0010_8000, 32'h0002_0000};

	int send_idle_pct;
	int recv_idle_pct;
	int holds_asked;
	int holds_started;
	int hold_left;
	int cycle_count;
	int mismatch_count;
	int results_seen;
	int beyond_seen;
	int loads_sent;
	int queries_sent;
	int settings_used;
	int input_stalls;

	cubic_table_interpolator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	function automatic longint unsigned tap_base(logic [RAD_W-1:0] rad);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(rad) * PROD_W'(step_reg);
		return prod[PROD_W-1:32];
	endfunction

	function automatic longint tap_value(longint unsigned idx);
		if (idx >= mesh_reg || idx >= TB_DEPTH)
			return 0;
		return longint'(sample_mem[idx]);
	endfunction

	function automatic interp_result_t compute_interp(logic [RAD_W-1:0] rad);
		logic [PROD_W-1:0] prod;
		longint unsigned   base, x0, x1, x2, x3;
		longint            w [NTAP];
		longint            acc, y;
		interp_result_t    res;
		int                k;
		prod = PROD_W'(rad) * PROD_W'(step_reg);
		base = prod[PROD_W-1:32];
		x0 = prod[31:16];
		x1 = 65536 - x0;
		x2 = 131072 - x0;
		x3 = 196608 - x0;
		res.value = '0;
		res.beyond = 1'b1;
		if (base >= mesh_reg)
			return res;
		// triple products in Q.48, down to Q.30, then the Lagrange denominators
		w[0] = longint'(((x1 * x2 * x3) >> 18) / 6);
		w[1] = longint'(((x0 * x2 * x3) >> 18) / 2);
		w[2] = -longint'(((x0 * x1 * x3) >> 18) / 2);
		w[3] = longint'(((x0 * x1 * x2) >> 18) / 6);
		acc = 0;
		for (k = 0; k < NTAP; k++)
			acc += tap_value(base + k) * w[k];
		y = (acc + (longint'(1) << 29)) >>> 30;
		if (y > 64'sd2147483647)
			y = 64'sd2147483647;
		if (y < -64'sd2147483648)
			y = -64'sd2147483648;
		res.value = 32'(y);
		res.beyond = 1'b0;
		return res;
	endfunction

	function automatic stim_row_t item_row(op_t op, logic [IDX_W-1:0] idx,
		logic [VAL_W-1:0] val, logic [RAD_W-1:0] rad, bit typed,
		logic [OUT_W-1:0] value, logic beyond);
		stim_row_t row;
		row.kind = ROW_ITEM;
		row.mesh = '0;
		row.step = '0;
		row.op = op;
		row.idx = idx;
		row.val = val;
		row.rad = rad;
		row.typed = typed;
		row.want.value = value;
		row.want.beyond = beyond;
		return row;
	endfunction

	function automatic stim_row_t setting_row(logic [MESH_W-1:0] mesh,
		logic [STEP_W-1:0] step);
		stim_row_t row;
		row = item_row(OP_LOAD, '0, '0, '0, 1'b0, '0, 1'b0);
		row.kind = ROW_SETTING;
		row.mesh = mesh;
		row.step = step;
		return row;
	endfunction

	task automatic flag_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("mismatch: %s", msg);
	endtask

	task automatic push_item(op_t op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val,
		logic [RAD_W-1:0] rad, bit typed, interp_result_t want);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= IN_DATA_W'({rad, val, idx});
		@(posedge clk);
		while (!s_tready) begin
			input_stalls++;
			@(posedge clk);
		end
		if (op == OP_LOAD) begin
			sample_mem[idx] = val;
			written_mem[idx] = 1'b1;
			loads_sent++;
		end else begin
			pending_results.push_back(typed ? want : compute_interp(rad));
			queries_sent++;
		end
	endtask

	// load every entry the query will read that has not been written yet
	task automatic send_query(logic [RAD_W-1:0] rad, bit typed, interp_result_t want);
		longint unsigned base, idx;
		int              k;
		base = tap_base(rad);
		if (base < mesh_reg) begin
			for (k = 0; k < NTAP; k++) begin
				idx = base + k;
				if (idx < mesh_reg && idx < TB_DEPTH && !written_mem[idx])
					push_item(OP_LOAD, IDX_W'(idx), VAL_W'($urandom), RAD_W'($urandom),
						1'b0, '0);
			end
		end
		push_item(OP_QUERY, IDX_W'($urandom), VAL_W'($urandom), rad, typed, want);
	endtask

	task automatic settle_pipeline();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(logic [MESH_W-1:0] mesh, logic [STEP_W-1:0] step);
		cfg_we <= 1'b1;
		cfg_index <= REG_MESH_COUNT;
		cfg_data <= CFG_W'(mesh);
		@(posedge clk);
		cfg_index <= REG_INV_STEP;
		cfg_data <= step;
		@(posedge clk);
		cfg_we <= 1'b0;
		mesh_reg = mesh;
		step_reg = step;
		settings_used++;
	endtask

	task automatic random_item();
		longint unsigned  target, lim;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
		logic [RAD_W-1:0] rad;
		if ($urandom_range(99) < 30) begin
			lim = (mesh_reg + 8 > TB_DEPTH - 1) ? TB_DEPTH - 1 : mesh_reg + 8;
			idx = $urandom_range(1) ? IDX_W'($urandom_range(0, int'(lim))) : IDX_W'($urandom);
			if ($urandom_range(9) == 0)
				val = $urandom_range(1) ? 24'h7F_FFFF : 24'h80_0000;
			else
				val = VAL_W'($urandom);
			push_item(OP_LOAD, idx, val, RAD_W'($urandom), 1'b0, '0);
		end else begin
			rad = RAD_W'($urandom);
			// aim most queries at the populated part of the grid and its edge
			if (step_reg != 0 && $urandom_range(99) < 60) begin
				target = (longint'($urandom_range(0, int'(mesh_reg) + 4)) << 32)
					| longint'($urandom_range(16'hFFFF, 0)) << 16
					| longint'($urandom_range(16'hFFFF, 0));
				target = target / step_reg;
				if (target <= 24'hFF_FFFF)
					rad = RAD_W'(target);
			end else if ($urandom_range(3) == 0) begin
				rad = RAD_W'($urandom_range(16'hFFFF, 0));
			end
			send_query(rad, 1'b0, '0);
		end
	endtask

	// receiver: random stalls, plus one long hold whenever the driver asks
	always @(posedge clk) begin
		if (hold_left == 0 && holds_started < holds_asked) begin
			hold_left = HOLD_CYCLES;
			holds_started++;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		interp_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result value=%h beyond=%b",
					m_tdata, m_tuser));
			end else begin
				want = pending_results.pop_front();
				if (m_tdata !== want.value || m_tuser !== want.beyond)
					flag_mismatch($sformatf(
						"result %0d: expected value=%h beyond=%b, got value=%h beyond=%b",
						results_seen, want.value, want.beyond, m_tdata, m_tuser));
				if (want.beyond)
					beyond_seen++;
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int p, n;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MESH_COUNT;
		cfg_data = '0;
		send_idle_pct = 32;
		recv_idle_pct = 61;
		phase_step[PHASES-1] = 32'h0002_0000 + $urandom_range(32'h0003_FFFF, 0);

		// reset values: no mesh yet, unit step
		dir_rows.push_back(item_row(OP_QUERY, '0, '0, 24'h00_0000, 1'b1, '0, 1'b1));
		dir_rows.push_back(item_row(OP_QUERY, '0, '0, 24'hFF_FFFF, 1'b1, '0, 1'b1));
		dir_rows.push_back(item_row(OP_LOAD, 12'd0, 24'h7F_FFFF, '0, 1'b0, '0, 1'b0));
		dir_rows.push_back(item_row(OP_LOAD, 12'd1, 24'h80_0000, '0, 1'b0, '0, 1'b0));
		dir_rows.push_back(item_row(OP_LOAD, 12'd2, 24'h00_0000, '0, 1'b0, '0, 1'b0));
		dir_rows.push_back(item_row(OP_LOAD, 12'd3, 24'h10_0000, '0, 1'b0, '0, 1'b0));
		dir_rows.push_back(item_row(OP_LOAD, 12'd4094, 24'h7F_FFFF, '0, 1'b0, '0, 1'b0));
		dir_rows.push_back(item_row(OP_LOAD, 12'd4095, 24'h80_0000, '0, 1'b0, '0, 1'b0));
		dir_rows.push_back(item_row(OP_LOAD, 12'd4, 24'h2A_AAAA, '0, 1'b0, '0, 1'b0));
		// four-entry mesh: grid points return the sample itself
		dir_rows.push_back(setting_row(13'd4, 32'h0001_0000));
		dir_rows.push_back(item_row(OP_QUERY, '0, '0, 24'h00_0000, 1'b1, 32'h007F_FFFF, 1'b0));
		dir_rows.push_back(item_row(OP_QUERY, '0, '0, 24'h01_0000, 1'b1, 32'hFF80_0000, 1'b0));
		dir_rows.push_back(item_row(OP_QUERY, '0, '0, 24'h03_0000, 1'b1, 32'h0010_0000, 1'b0));
		dir_rows.push_back(item_row(OP_QUERY, '0, '0, 24'h04_0000, 1'b1, '0, 1'b1));
		dir_rows.push_back(item_row(OP_QUERY, '0, '0, 24'h00_8000, 1'b0, '0, 1'b0));
		dir_rows.push_back(item_row(OP_QUERY, '0, '0, 24'h02_8000, 1'b0, '0, 1'b0));
		dir_rows.push_back(item_row(OP_QUERY, '0, '0, 24'h03_8000, 1'b0, '0, 1'b0));
		dir_rows.push_back(item_row(OP_QUERY, '0, '0, 24'hFF_FFFF, 1'b1, '0, 1'b1));
		// full mesh, step 16: neighbours run past the last table entry
		dir_rows.push_back(setting_row(13'd4096, 32'h0010_0000));
		dir_rows.push_back(item_row(OP_QUERY, '0, '0, 24'hFF_E000, 1'b0, '0, 1'b0));
		dir_rows.push_back(item_row(OP_QUERY, '0, '0, 24'hFF_F800, 1'b0, '0, 1'b0));
		dir_rows.push_back(item_row(OP_QUERY, '0, '0, 24'hFF_FFFF, 1'b0, '0, 1'b0));
		dir_rows.push_back(item_row(OP_QUERY, '0, '0, 24'h00_0000, 1'b1, 32'h007F_FFFF, 1'b0));
		// zero step pins every query to entry zero; a load is seen at once
		dir_rows.push_back(setting_row(13'd4096, 32'h0000_0000));
		dir_rows.push_back(item_row(OP_QUERY, '0, '0, 24'hFF_FFFF, 1'b1, 32'h007F_FFFF, 1'b0));
		dir_rows.push_back(item_row(OP_LOAD, 12'd0, 24'h00_0001, '0, 1'b0, '0, 1'b0));
		dir_rows.push_back(item_row(OP_QUERY, '0, '0, 24'h12_3456, 1'b1, 32'h0000_0001, 1'b0));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_SETTING) begin
				settle_pipeline();
				write_regs(dir_rows[i].mesh, dir_rows[i].step);
			end else if (dir_rows[i].op == OP_LOAD) begin
				push_item(OP_LOAD, dir_rows[i].idx, dir_rows[i].val, RAD_W'($urandom),
					1'b0, '0);
			end else begin
				send_query(dir_rows[i].rad, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		for (p = 0; p < PHASES; p++) begin
			settle_pipeline();
			write_regs(phase_mesh[p], phase_step[p]);
			send_idle_pct = (p < 2) ? 32 : (p < 4) ? 61 : 0;
			recv_idle_pct = (p < 2) ? 61 : (p < 4) ? 32 : 0;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// hold the output for a long stretch while items keep coming
				if (n == PHASE_ITEMS / 4)
					holds_asked++;
				random_item();
			end
		end

		settle_pipeline();
		if (pending_results.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		$display("covered %0d loads and %0d queries over %0d register settings",
			loads_sent, queries_sent, settings_used);
		$display("checked %0d results (%0d beyond the table), input stalled %0d cycles",
			results_seen, beyond_seen, input_stalls);
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- cubic_table_interpolator_unit.f -----
sv/ctiu_pkg.sv
sv/ctiu_ram.sv
sv/ctiu_table.sv
sv/ctiu_weights.sv
sv/ctiu_mac.sv
sv/cubic_table_interpolator_unit.sv
sv/ctiu_checker.sv
tb/tb.sv
